### design/sorted_priority_queue_macros.svh
// Assertion macros used by the sorted priority queue top-level design file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/spq_pkg.sv
// Package with the types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned KEY_WIDTH     = 32;
  localparam int unsigned TAG_WIDTH     = 8;
  localparam int unsigned OCC_WIDTH     = 5;
  localparam int unsigned DEFAULT_DEPTH = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                   opcode;
    logic [KEY_WIDTH-1:0]  new_key;
    logic [TAG_WIDTH-1:0]  new_tag;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [KEY_WIDTH-1:0]  out_key;
    logic [TAG_WIDTH-1:0]  out_tag;
    logic [OCC_WIDTH-1:0]  occupancy;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [KEY_WIDTH-1:0]  key;
    logic [TAG_WIDTH-1:0]  tag;
  } cell_cmd_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic [KEY_WIDTH-1:0]  key;
    logic [TAG_WIDTH-1:0]  tag;
    logic                  ge;
  } cell_link_t;

endpackage

### design/sorted_priority_queue.sv
// Sorted priority queue, largest key first: a row of cells plus a result register.
//
// Requests arrive on req (req_valid/req_ready). An insert stores new_key and
// new_tag behind every stored entry with a key greater or equal, so equal keys
// leave in arrival order; a removal returns the head entry. Every request
// gives exactly one response on rsp (rsp_valid/rsp_ready) carrying a status,
// the removed key and tag (zero when nothing is removed) and the occupancy
// after the operation.
// The response is registered at the request transfer edge and offered from
// the next cycle. Throughput is one request per cycle unless the receiver stalls;
// all DEPTH cells compare against the broadcast key and shift in the same
// cycle, so the chain length only sets the fan-out of that broadcast.
// Reset empties the queue (the entry count goes to zero) and drops any
// pending response; cell contents need no clearing and no sweep is run.
// While the receiver stalls, the response is held and req_ready falls, so
// at most one response is ever waiting.
`timescale 1ns / 1ps
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

  logic [CNT_WIDTH-1:0] count;
  logic [CNT_WIDTH-1:0] count_next;
  rsp_t                 rsp_next;
  logic                 rsp_valid_next;
  logic                 take;
  logic                 full;
  logic                 empty;
  cell_cmd_t            cmd;
  cell_link_t           links [DEPTH];
  logic [DEPTH-1:0]     valid;

  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;
  assign full      = (count == CNT_WIDTH'(DEPTH));
  assign empty     = (count == '0);

  assign cmd.ins = take && (req.opcode == OP_INSERT) && !full;
  assign cmd.rem = take && (req.opcode == OP_REMOVE) && !empty;
  assign cmd.key = req.new_key;
  assign cmd.tag = req.new_tag;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    assign valid[i] = (count > CNT_WIDTH'(i));

    if (i == 0) begin : g_head
      // The head has nothing in front of it to hold the new key back.
      assign left_link = '{key: '0, tag: '0, ge: 1'b1};
    end else begin : g_body
      assign left_link = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_link = '{key: '0, tag: '0, ge: 1'b0};
    end else begin : g_inner
      assign right_link = links[i+1];
    end

    spq_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .valid (valid[i]),
      .left  (left_link),
      .right (right_link),
      .link  (links[i])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_WIDTH'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_WIDTH'(1);
    end
  end

  always_comb begin
    rsp_next.status    = STATUS_DONE;
    rsp_next.out_key   = '0;
    rsp_next.out_tag   = '0;
    rsp_next.occupancy = OCC_WIDTH'(count_next);
    case (req.opcode)
      OP_INSERT: begin
        if (full) begin
          rsp_next.status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          rsp_next.status = STATUS_EMPTY;
        end else begin
          rsp_next.out_key = links[0].key;
          rsp_next.out_tag = links[0].tag;
        end
      end
      default: begin
        rsp_next.status = STATUS_DONE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (take) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

`include "sorted_priority_queue_macros.svh"

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_WIDTH'(DEPTH),
    "entry count beyond depth")
  `SPQ_ASSERT_NOW(a_head_order, count >= CNT_WIDTH'(2),
    $signed(links[0].key) >= $signed(links[1].key),
    "head entry smaller than its successor")
  `SPQ_ASSERT_NEXT(a_insert_count, cmd.ins, count == $past(count) + CNT_WIDTH'(1),
    "insert did not raise the count")
  `SPQ_ASSERT_NEXT(a_remove_head, cmd.rem,
    rsp_valid && (rsp.out_key == $past(links[0].key)),
    "removal did not return the head key")
  `SPQ_ASSERT_NEXT(a_full_hold, take && (req.opcode == OP_INSERT) && full,
    (count == $past(count)) && (rsp.status == STATUS_FULL),
    "refused insert changed the queue")

endmodule

### design/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it left or right.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic       valid,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic [KEY_WIDTH-1:0] key;
  logic [TAG_WIDTH-1:0] tag;
  logic [KEY_WIDTH-1:0] key_next;
  logic [TAG_WIDTH-1:0] tag_next;
  logic                 ge;

  // A stored entry at least as large as the new key stays where it is.
  assign ge = valid && ($signed(key) >= $signed(cmd.key));

  always_comb begin
    key_next = key;
    tag_next = tag;
    if (cmd.ins) begin
      if (!ge) begin
        if (left.ge) begin
          key_next = cmd.key;
          tag_next = cmd.tag;
        end else begin
          key_next = left.key;
          tag_next = left.tag;
        end
      end
    end else if (cmd.rem) begin
      key_next = right.key;
      tag_next = right.tag;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

  assign link.key = key;
  assign link.tag = tag;
  assign link.ge  = ge;

endmodule

### tb/sorted_priority_queue_tb.sv
// Self-checking testbench of the sorted priority queue, with a behavioural queue model.
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Behavioural copy of the queue contents, head at index 0.
  logic signed [KEY_WIDTH-1:0] model_key [DEPTH];
  logic [TAG_WIDTH-1:0]        model_tag [DEPTH];
  int                          model_count = 0;
  rsp_t                        predicted_rsp [$];

  sorted_priority_queue #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic rsp_t predict_queue_op(input req_t r);
    rsp_t res;
    int   pos;
    res = '0;
    res.status = STATUS_DONE;
    if (r.opcode == OP_INSERT) begin
      if (model_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = 0;
        // Equal keys go behind the stored ones so that they leave in arrival order.
        while (pos < model_count && model_key[pos] >= $signed(r.new_key)) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_key[i] = model_key[i-1];
          model_tag[i] = model_tag[i-1];
        end
        model_key[pos] = $signed(r.new_key);
        model_tag[pos] = r.new_tag;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_key = model_key[0];
        res.out_tag = model_tag[0];
        for (int i = 1; i < model_count; i++) begin
          model_key[i-1] = model_key[i];
          model_tag[i-1] = model_tag[i];
        end
        model_count--;
      end
    end
    res.occupancy = OCC_WIDTH'(model_count);
    return res;
  endfunction

  // Requests are predicted before responses are checked, so a transfer on each side
  // at the same edge is handled in the right order.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) predicted_rsp.push_back(predict_queue_op(req));
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          error_count++;
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            error_count++;
          end
          if (rsp.out_key !== want.out_key) begin
            $error("out_key: expected %0d, actual %0d",
                   $signed(want.out_key), $signed(rsp.out_key));
            error_count++;
          end
          if (rsp.out_tag !== want.out_tag) begin
            $error("out_tag: expected %0d, actual %0d", want.out_tag, rsp.out_tag);
            error_count++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp.occupancy);
            error_count++;
          end
        end
      end
    end
  end

  // Valid stays high from one request to the next unless the sender chooses to idle.
  task automatic send_request(input op_t op, input logic [KEY_WIDTH-1:0] key,
                              input logic [TAG_WIDTH-1:0] tag);
    req_t item;
    item.opcode  = op;
    item.new_key = key;
    item.new_tag = tag;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req       <= req_t'({$urandom(), $urandom()});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [KEY_WIDTH-1:0] random_key();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return KEY_WIDTH'($signed($urandom_range(7)) - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_removal();
    send_request(OP_REMOVE, 32'hffff_ffff, 8'hff);
  endtask

  // Fills the queue with extreme and repeated keys, then offers one more entry.
  task automatic test_fill_and_overflow();
    send_request(OP_INSERT, 32'h8000_0000, 8'h00);
    send_request(OP_INSERT, 32'h0000_0000, 8'h01);
    send_request(OP_INSERT, 32'hffff_ffff, 8'h02);
    send_request(OP_INSERT, 32'h7fff_ffff, 8'ha5);
    send_request(OP_INSERT, 32'h0000_0001, 8'h03);
    send_request(OP_INSERT, 32'h7fff_ffff, 8'h5a);
    send_request(OP_INSERT, 32'h8000_0000, 8'hff);
    for (int i = 0; i < DEPTH - 7; i++) send_request(OP_INSERT, random_key(), 8'(i + 16));
    send_request(OP_INSERT, 32'h7fff_ffff, 8'hee);
  endtask

  // The two largest equal keys must come out first and in arrival order.
  task automatic test_ordered_removal();
    for (int i = 0; i < 5; i++) send_request(OP_REMOVE, $urandom(), 8'($urandom()));
  endtask

  // Bursts that lean to inserts or removals sweep the occupancy between empty and full.
  task automatic test_random_traffic(input int items, input int sender_idle,
                                     input int receiver_idle);
    int sent;
    int burst;
    int insert_pct;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(24, 1);
      case ($urandom_range(9))
        0, 1, 2, 3: insert_pct = 90;
        4, 5, 6, 7: insert_pct = 10;
        default:    insert_pct = 50;
      endcase
      for (int i = 0; i < burst && sent < items; i++) begin
        if ($urandom_range(99) < insert_pct)
          send_request(OP_INSERT, random_key(), 8'($urandom_range(255)));
        else
          send_request(OP_REMOVE, $urandom(), 8'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_removal();
    test_fill_and_overflow();
    test_ordered_removal();
    test_random_traffic(530, 26, 83);
    test_random_traffic(530, 83, 26);
    test_random_traffic(540, 0, 0);

    req_valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
